FILE: rtl/core/bcev_pkg.sv
// Shared constants and types for the breakpoint curve evaluator.
package bcev_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int POS_W      = 32;
    localparam int LVL_W      = 32;
    localparam int BEND_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_EVAL  = 1'b1;
    localparam logic [14:0] BEND_ONE  = 15'd16384;

    typedef struct packed {
        logic                     is_eval;
        logic [PT_AW-1:0]         slot;
        logic [POS_W-1:0]         position;
        logic signed [LVL_W-1:0]  point_level;
        logic signed [BEND_W-1:0] bend;
        logic                     hold_flag;
    } t_item;

endpackage

FILE: rtl/core/bcev_front.sv
// Front end: takes commands, tags them as write or evaluate, and queues them.
module bcev_front
    import bcev_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_func,
    input  logic [PT_AW-1:0]         i_slot,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [LVL_W-1:0]  i_point_level,
    input  logic signed [BEND_W-1:0] i_bend,
    input  logic                     i_hold_flag,
    output logic                     o_item_valid,
    output t_item                    o_item,
    input  logic                     i_pop
);

    t_item r_q [QUEUE_DEPTH];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic  push;
    t_item item;

    // Classify the incoming beat
    always_comb begin
        item.is_eval     = (i_func == FUNC_EVAL);
        item.slot        = i_slot;
        item.position    = i_position;
        item.point_level = i_point_level;
        item.bend        = i_bend;
        item.hold_flag   = i_hold_flag;
    end

    assign busy         = (r_cnt == 2'(QUEUE_DEPTH));
    assign push         = start && !busy;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    // Store payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

FILE: rtl/core/bcev_back.sv
// Back end: breakpoint memories, segment search, fraction divider and interpolation.
module bcev_back
    import bcev_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CNT_W-1:0]        i_points,
    input  logic                    i_item_valid,
    input  t_item                   i_item,
    output logic                    o_pop,
    output logic                    o_result_strobe,
    output logic signed [LVL_W-1:0] o_curve_value,
    output logic                    o_has_value
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_RDL2  = 4'd3;
    localparam logic [3:0] S_RDR   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_MUL1  = 4'd6;
    localparam logic [3:0] S_MUL2  = 4'd7;
    localparam logic [3:0] S_SHAPE = 4'd8;
    localparam logic [3:0] S_MUL3  = 4'd9;
    localparam logic [3:0] S_SUM   = 4'd10;

    // Breakpoint memories
    logic [POS_W-1:0]         mem_pos  [MAX_POINTS];
    logic signed [LVL_W-1:0]  mem_lvl  [MAX_POINTS];
    logic signed [BEND_W-1:0] mem_bend [MAX_POINTS];
    logic                     mem_hold [MAX_POINTS];

    logic [POS_W-1:0]         r_rd_pos;
    logic signed [LVL_W-1:0]  r_rd_lvl;
    logic signed [BEND_W-1:0] r_rd_bend;
    logic                     r_rd_hold;

    logic [3:0]               r_state;
    logic [POS_W-1:0]         r_qpos;
    logic [CNT_W-1:0]         r_issue, r_pend_idx, r_r;
    logic                     r_pend;
    logic [POS_W-1:0]         r_lpos;
    logic signed [LVL_W-1:0]  r_llev, r_rlev;
    logic signed [BEND_W-1:0] r_lbend;
    logic                     r_lhold;
    logic [POS_W-1:0]         r_rem, r_den;
    logic [3:0]               r_dcnt;
    logic [FRAC_W-1:0]        r_f;
    logic [30:0]              r_m;
    logic [45:0]              r_p;
    logic [16:0]              r_s;
    logic signed [50:0]       r_prod;

    logic                     r_out_stb;
    logic signed [LVL_W-1:0]  r_out_val;
    logic                     r_out_has;

    logic                     wr_en;
    logic [PT_AW-1:0]         rd_addr;
    logic [CNT_W-1:0]         l_idx;
    logic [POS_W:0]           rem2;
    logic                     neg_c;
    logic [14:0]              abs_c;
    logic [47:0]              f30, shaped, shaped_r;
    logic [32:0]              m_full;
    logic signed [32:0]       diff;
    logic signed [17:0]       s_sgn;
    logic signed [50:0]       prod;
    logic signed [51:0]       sum;
    logic signed [35:0]       vs;
    logic signed [LVL_W-1:0]  sat;

    assign o_pop = (r_state == S_IDLE) && i_item_valid;
    assign wr_en = o_pop && !i_item.is_eval;
    assign l_idx = (r_r == '0) ? '0 : r_r - CNT_W'(1);

    // Select the read address for the current step
    always_comb begin
        unique case (r_state)
            S_SRCH:  rd_addr = r_issue[PT_AW-1:0];
            S_RDL:   rd_addr = l_idx[PT_AW-1:0];
            default: rd_addr = r_r[PT_AW-1:0];
        endcase
    end

    // Write and read the breakpoint memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_pos[i_item.slot]  <= i_item.position;
            mem_lvl[i_item.slot]  <= i_item.point_level;
            mem_bend[i_item.slot] <= i_item.bend;
            mem_hold[i_item.slot] <= i_item.hold_flag;
        end
        r_rd_pos  <= mem_pos[rd_addr];
        r_rd_lvl  <= mem_lvl[rd_addr];
        r_rd_bend <= mem_bend[rd_addr];
        r_rd_hold <= mem_hold[rd_addr];
    end

    // Arithmetic helpers
    always_comb begin
        rem2  = {r_rem, 1'b0};
        neg_c = r_lbend[BEND_W-1];
        if (r_lbend > $signed(16'(BEND_ONE)) || r_lbend < -$signed(16'(BEND_ONE))) begin
            abs_c = BEND_ONE;
        end else if (neg_c) begin
            abs_c = 15'(-r_lbend);
        end else begin
            abs_c = 15'(r_lbend);
        end
        m_full   = 33'(r_f) * (33'd65536 - 33'(r_f));
        f30      = {2'b0, r_f, 30'b0};
        shaped   = neg_c ? f30 + {2'b0, r_p} : f30 - {2'b0, r_p};
        shaped_r = shaped + 48'(1 << 29);
        diff     = $signed({r_rlev[LVL_W-1], r_rlev}) - $signed({r_llev[LVL_W-1], r_llev});
        s_sgn    = $signed({1'b0, r_s});
        prod     = diff * s_sgn;
        sum      = $signed({{4{r_llev[LVL_W-1]}}, r_llev, 16'b0})
                 + $signed({r_prod[50], r_prod}) + 52'sd32768;
        vs       = sum[51:16];
        if (vs > 36'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (vs < -36'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = vs[31:0];
        end
    end

    // Payload registers for each step
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qpos <= i_item.position;
            end
            S_SRCH: begin
                if (r_pend && r_qpos < r_rd_pos) begin
                    r_r <= r_pend_idx;
                end else begin
                    r_r <= i_points;
                end
            end
            S_RDL2: begin
                r_lpos  <= r_rd_pos;
                r_llev  <= r_rd_lvl;
                r_lbend <= r_rd_bend;
                r_lhold <= r_rd_hold;
            end
            S_RDR: begin
                r_rlev <= r_rd_lvl;
                r_rem  <= r_qpos - r_lpos;
                r_den  <= r_rd_pos - r_lpos;
                r_f    <= '0;
            end
            S_DIV: begin
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem <= 32'(rem2 - {1'b0, r_den});
                    r_f   <= {r_f[FRAC_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2[POS_W-1:0];
                    r_f   <= {r_f[FRAC_W-2:0], 1'b0};
                end
            end
            S_MUL1:  r_m    <= m_full[30:0];
            S_MUL2:  r_p    <= 46'(abs_c) * 46'(r_m);
            S_SHAPE: r_s    <= shaped_r[46:30];
            S_MUL3:  r_prod <= prod;
            default: ;
        endcase
    end

    // Sequence each evaluation through search, divide and interpolate; writes end in idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= '0;
            r_pend     <= 1'b0;
            r_pend_idx <= '0;
            r_dcnt     <= '0;
            r_out_stb  <= 1'b0;
            r_out_val  <= '0;
            r_out_has  <= 1'b0;
        end else begin
            r_out_stb <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_issue <= '0;
                    r_pend  <= 1'b0;
                    if (i_item_valid) begin
                        if (!i_item.is_eval || i_points == '0) begin
                            r_out_stb <= 1'b1;
                            r_out_val <= '0;
                            r_out_has <= 1'b0;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (r_pend && r_qpos < r_rd_pos) begin
                        r_state <= S_RDL;
                    end else if (r_issue < i_points) begin
                        r_issue    <= r_issue + CNT_W'(1);
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_issue;
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                    end else begin
                        r_state <= S_RDL;
                    end
                end
                S_RDL:  r_state <= S_RDL2;
                S_RDL2: r_state <= S_RDR;
                S_RDR: begin
                    if (r_r == '0 || r_r == i_points || r_lhold) begin
                        r_out_stb <= 1'b1;
                        r_out_val <= r_llev;
                        r_out_has <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (r_rd_pos < r_lpos) begin
                        // wrapped span: the fraction is zero
                        r_state <= S_MUL1;
                    end else begin
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= S_SHAPE;
                S_SHAPE: r_state <= S_MUL3;
                S_MUL3:  r_state <= S_SUM;
                S_SUM: begin
                    r_out_stb <= 1'b1;
                    r_out_val <= sat;
                    r_out_has <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_strobe = r_out_stb;
    assign o_curve_value   = r_out_val;
    assign o_has_value     = r_out_has;

endmodule

FILE: rtl/core/breakpoint_curve_evaluator_unit.sv
// Top level of the breakpoint curve evaluator.
// Commands enter on start while busy is low, one beat per cycle at most:
// func 0 stores a breakpoint into a slot, func 1 evaluates the curve at position.
// A two-entry queue sits between the command front end and the execution back end,
// so two commands may be taken while an earlier one is still being worked on.
// Every command yields one result beat on o_result_strobe, one cycle wide; the
// receiver cannot stall it. Writes and an empty table give has_value 0.
// A write or an empty table is answered straight from the idle state. An evaluation
// walks the position memory one slot per cycle and reads the two segment ends; then a
// hold point or a position outside the table returns a breakpoint level, else a
// restoring divider (skipped for a wrapped span) forms the 16-bit fraction, and
// five multiply/add steps follow. Values of points_in_use above 64 saturate to 64.
// The single back-end sequencer takes the next command in the cycle after it ends
// the last: one write per cycle, and an evaluation must end before the next is taken.
// points_in_use is written on the cfg channel (always ready); the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Reset clears the queue, the sequencer and points_in_use; memory contents stay
// undefined until written.
module breakpoint_curve_evaluator_unit
    import bcev_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_func,
    input  logic [PT_AW-1:0]         i_slot,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [LVL_W-1:0]  i_point_level,
    input  logic signed [BEND_W-1:0] i_bend,
    input  logic                     i_hold_flag,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CNT_W-1:0]         i_cfg_data,
    output logic                     o_result_strobe,
    output logic signed [LVL_W-1:0]  o_curve_value,
    output logic                     o_has_value
);

    logic [CNT_W-1:0] r_points;
    logic             item_valid, pop;
    t_item            item;

    assign o_cfg_ready = 1'b1;

    // Hold the number of slots in use, saturated to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_points <= (i_cfg_data > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : i_cfg_data;
        end
    end

    bcev_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_position    (i_position),
        .i_point_level (i_point_level),
        .i_bend        (i_bend),
        .i_hold_flag   (i_hold_flag),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_pop         (pop)
    );

    bcev_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_points        (r_points),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_pop           (pop),
        .o_result_strobe (o_result_strobe),
        .o_curve_value   (o_curve_value),
        .o_has_value     (o_has_value)
    );

endmodule
